[rtl/core/pfa_pkg.sv]
package pfa_pkg;

	localparam int DEF_MAX_FRAMES = 256;
	localparam int DEF_PID_BITS   = 16;

	localparam int REQ_W   = 2;
	localparam int PID_W   = 16;
	localparam int BYTES_W = 24;
	localparam int PAGE_W  = 8;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 9;
	localparam int PSIZE_W = 17;

	localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST   = 17'd4096;
	localparam logic [CNT_W-1:0]   FRAME_COUNT_RST = 9'd256;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC  = 2'd0,
		REQ_FREE   = 2'd1,
		REQ_LOOKUP = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_NOSPACE  = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic {
		CFG_PAGE_SIZE   = 1'b0,
		CFG_FRAME_COUNT = 1'b1
	} cfg_idx_t;

endpackage

[rtl/core/page_frame_allocator_core.sv]
// Free and lookup scan the frame table after start and then raise done; allocate first
// runs a one-bit-per-cycle page-count divider and a free-frame check ahead of the scan.
// Throughput: one request at a time; the scan reads one table entry per cycle from the
// single frame-table memory. done is a one-cycle strobe; the receiver cannot stall.
// Reset and every frame_count write start a clearing pass over all MAX_FRAMES entries
// with busy high; configuration writes are always taken.
module page_frame_allocator_core import pfa_pkg::*; #(
	parameter int MAX_FRAMES = DEF_MAX_FRAMES,
	parameter int PID_BITS   = DEF_PID_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [PID_W-1:0]   pid,
	input  logic [BYTES_W-1:0] process_bytes,
	input  logic [PAGE_W-1:0]  page_index,
	output logic               done,
	output logic [STAT_W-1:0]  status,
	output logic [PAGE_W-1:0]  frame_index,
	output logic [CNT_W-1:0]   frames_changed,
	output logic [CNT_W-1:0]   free_frames,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [PSIZE_W-1:0] cfg_data
);

	localparam int AW  = $clog2(MAX_FRAMES);
	localparam int PW  = AW + 1;
	localparam int CW  = (PW > CNT_W) ? PW : CNT_W;
	localparam int OW  = (PID_BITS < PID_W) ? PID_BITS : PID_W;
	localparam int PGW = BYTES_W + 1;
	localparam int DCW = $clog2(BYTES_W);
	localparam int SAT = (MAX_FRAMES > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : MAX_FRAMES;
	localparam logic [CNT_W-1:0] FC_SAT   = CNT_W'(SAT);
	localparam logic [PW-1:0]    CLR_LAST = PW'(MAX_FRAMES - 1);
	localparam logic [DCW-1:0]   DIV_LAST = DCW'(BYTES_W - 1);

	typedef struct packed {
		logic              busy;
		logic [OW-1:0]     owner;
		logic [PAGE_W-1:0] page;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_DIV,
		S_CHK,
		S_SCAN,
		S_OUT
	} state_t;

	entry_t mem_q [MAX_FRAMES];
	entry_t rdata_s1;

	state_t              state_q;
	logic [PSIZE_W-1:0]  psize_q;
	logic [CNT_W-1:0]    fc_q;
	logic [CNT_W-1:0]    free_q;
	req_t                req_q;
	logic [OW-1:0]       pid_q;
	logic [PAGE_W-1:0]   want_q;
	logic [BYTES_W-1:0]  quo_q;
	logic [PSIZE_W-1:0]  rem_q;
	logic [DCW-1:0]      dcnt_q;
	logic [PGW-1:0]      pages_q;
	logic [PW-1:0]       ptr_q;
	logic                v_s1;
	logic [AW-1:0]       a_s1;
	logic [CNT_W-1:0]    chg_q;
	logic                found_q;
	logic [AW-1:0]       fidx_q;
	logic                done_q;
	logic [STAT_W-1:0]   status_q;
	logic [PAGE_W-1:0]   frame_q;
	logic [CNT_W-1:0]    changed_q;
	logic [CNT_W-1:0]    free_out_q;

	logic [PSIZE_W-1:0]  ps_eff;
	logic [PSIZE_W:0]    rem_try;
	logic                rem_ge;
	logic [PSIZE_W:0]    rem_sub;
	logic [BYTES_W-1:0]  quo_nxt;
	logic                rd_go;
	logic                scan_end;
	logic                hit_own;
	logic                alloc_take;
	logic                free_take;
	logic                look_hit;
	logic                we;
	logic [AW-1:0]       waddr;
	entry_t              wdata;
	logic [AW+PAGE_W-1:0] fidx_ext;
	logic [CNT_W-1:0]    cfg_fc;

	assign ps_eff   = (psize_q == '0) ? PSIZE_W'(1) : psize_q;
	assign rem_try  = {rem_q, quo_q[BYTES_W-1]};
	assign rem_ge   = rem_try >= {1'b0, ps_eff};
	assign rem_sub  = rem_try - {1'b0, ps_eff};
	assign quo_nxt  = {quo_q[BYTES_W-2:0], rem_ge};

	assign rd_go    = (state_q == S_SCAN) && (CW'(ptr_q) < CW'(fc_q));
	assign scan_end = (state_q == S_SCAN) && !rd_go && !v_s1;

	assign hit_own    = rdata_s1.busy && (rdata_s1.owner == pid_q);
	assign alloc_take = v_s1 && (req_q == REQ_ALLOC) && !rdata_s1.busy &&
	                    (PGW'(chg_q) < pages_q);
	assign free_take  = v_s1 && (req_q == REQ_FREE) && hit_own;
	assign look_hit   = v_s1 && (req_q == REQ_LOOKUP) && hit_own &&
	                    (rdata_s1.page == want_q) && !found_q;

	assign fidx_ext = {{PAGE_W{1'b0}}, fidx_q};
	assign cfg_fc   = (cfg_data[CNT_W-1:0] > FC_SAT) ? FC_SAT : cfg_data[CNT_W-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = a_s1;
		wdata = rdata_s1;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = ptr_q[AW-1:0];
			wdata = '0;
		end else if (alloc_take) begin
			we          = 1'b1;
			wdata.busy  = 1'b1;
			wdata.owner = pid_q;
			wdata.page  = chg_q[PAGE_W-1:0];
		end else if (free_take) begin
			we         = 1'b1;
			wdata.busy = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_go) begin
			rdata_s1 <= mem_q[ptr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			psize_q    <= PAGE_SIZE_RST;
			fc_q       <= (FRAME_COUNT_RST > FC_SAT) ? FC_SAT : FRAME_COUNT_RST;
			free_q     <= (FRAME_COUNT_RST > FC_SAT) ? FC_SAT : FRAME_COUNT_RST;
			req_q      <= REQ_NONE;
			pid_q      <= '0;
			want_q     <= '0;
			quo_q      <= '0;
			rem_q      <= '0;
			pages_q    <= '0;
			ptr_q      <= '0;
			dcnt_q     <= '0;
			v_s1       <= 1'b0;
			a_s1       <= '0;
			chg_q      <= '0;
			found_q    <= 1'b0;
			fidx_q     <= '0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
			frame_q    <= '0;
			changed_q  <= '0;
			free_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= rd_go;
			a_s1   <= ptr_q[AW-1:0];
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req_t'(req_type);
						pid_q   <= pid[OW-1:0];
						want_q  <= page_index;
						quo_q   <= process_bytes;
						rem_q   <= '0;
						dcnt_q  <= '0;
						chg_q   <= '0;
						found_q <= 1'b0;
						ptr_q   <= '0;
						unique case (req_t'(req_type))
							REQ_ALLOC:  state_q <= S_DIV;
							REQ_FREE:   state_q <= S_SCAN;
							REQ_LOOKUP: state_q <= S_SCAN;
							REQ_NONE: begin
								status_q   <= ST_OK;
								frame_q    <= '0;
								changed_q  <= '0;
								free_out_q <= free_q;
								done_q     <= 1'b1;
								state_q    <= S_OUT;
							end
						endcase
					end
				end
				S_DIV: begin
					quo_q  <= quo_nxt;
					rem_q  <= rem_ge ? rem_sub[PSIZE_W-1:0] : rem_try[PSIZE_W-1:0];
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DIV_LAST) begin
						pages_q <= PGW'(quo_nxt) + PGW'(1);
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (pages_q > PGW'(free_q)) begin
						status_q   <= ST_NOSPACE;
						frame_q    <= '0;
						changed_q  <= '0;
						free_out_q <= free_q;
						done_q     <= 1'b1;
						state_q    <= S_OUT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_go) begin
						ptr_q <= ptr_q + PW'(1);
					end
					if (alloc_take || free_take) begin
						chg_q <= chg_q + CNT_W'(1);
					end
					if (look_hit) begin
						found_q <= 1'b1;
						fidx_q  <= a_s1;
					end
					if (scan_end) begin
						done_q  <= 1'b1;
						state_q <= S_OUT;
						frame_q <= '0;
						unique case (req_q)
							REQ_ALLOC: begin
								status_q   <= ST_OK;
								changed_q  <= chg_q;
								free_q     <= free_q - chg_q;
								free_out_q <= free_q - chg_q;
							end
							REQ_FREE: begin
								status_q   <= ST_OK;
								changed_q  <= chg_q;
								free_q     <= free_q + chg_q;
								free_out_q <= free_q + chg_q;
							end
							REQ_LOOKUP: begin
								status_q   <= found_q ? ST_OK : ST_NOTFOUND;
								frame_q    <= found_q ? fidx_ext[PAGE_W-1:0] : '0;
								changed_q  <= '0;
								free_out_q <= free_q;
							end
							REQ_NONE: begin
								status_q   <= ST_OK;
								changed_q  <= '0;
								free_out_q <= free_q;
							end
						endcase
					end
				end
				S_CLEAR: begin
					ptr_q <= ptr_q + PW'(1);
					if (ptr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_PAGE_SIZE: begin
						psize_q <= cfg_data;
					end
					CFG_FRAME_COUNT: begin
						fc_q    <= cfg_fc;
						free_q  <= cfg_fc;
						ptr_q   <= '0;
						state_q <= S_CLEAR;
					end
				endcase
			end
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign cfg_ready      = 1'b1;
	assign done           = done_q;
	assign status         = status_q;
	assign frame_index    = frame_q;
	assign frames_changed = changed_q;
	assign free_frames    = free_out_q;

endmodule

[rtl/core/pfa_checker.sv]
module pfa_checker import pfa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [STAT_W-1:0]  status,
	input logic [PAGE_W-1:0]  frame_index,
	input logic [CNT_W-1:0]   frames_changed
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after a request transfer");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_nospace_nochange: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_NOSPACE)) |-> (frames_changed == '0))
		else $error("failed allocate reports changed frames");

	a_frame_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (frame_index != '0)) |-> (status == ST_OK && frames_changed == '0))
		else $error("frame index reported without a successful lookup");

endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (.*);
